// ===== rtl/core/cluster_map_lru_cache_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cluster map cache
// Concurrent checks sampled on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_MAP_LRU_CACHE_UNIT_ASSERT_SVH
`define CLUSTER_MAP_LRU_CACHE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge
`define CLMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never holds
`define CLMC_ASSERT_NEVER(lbl, cond, msg) \
  `CLMC_ASSERT(lbl, !(cond), msg)
`else
`define CLMC_ASSERT(lbl, prop, msg)
`define CLMC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/clmc_pkg.sv =====
// ----------------------------------------------------------------------------
// clmc_pkg
// Types and constants shared by the cluster map cache modules.
// ----------------------------------------------------------------------------
`default_nettype none

package clmc_pkg;

  // Default number of cache entries
  localparam int unsigned CacheEntriesDef = 8;

  // Operation codes
  localparam logic [1:0] FuncLookup = 2'd0;
  localparam logic [1:0] FuncAdd    = 2'd1;
  localparam logic [1:0] FuncInval  = 2'd2;

  // Request item
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] file_start;
    logic [15:0] req_index;
    logic [15:0] req_disk;
    logic [15:0] hint_file;
    logic [15:0] hint_disk;
  } clmc_req_t;

  // Result item
  typedef struct packed {
    logic [15:0] found_file;
    logic [15:0] found_disk;
    logic [15:0] new_hint_file;
    logic [15:0] new_hint_disk;
    logic        corrupt;
  } clmc_rsp_t;

  // One cached translation; owner zero means free
  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] index;
    logic [15:0] disk;
  } clmc_entry_t;

  // Per-cell update control
  typedef struct packed {
    logic shift;   // take the neighbor's entry
    logic clear;   // free the entry if it belongs to the request's file
  } clmc_cell_ctl_t;

  // Per-cell compare flags
  typedef struct packed {
    logic cand;    // same file, index not above the request
    logic hit;     // same file, index equals the old hint
  } clmc_cell_flag_t;

endpackage

`default_nettype wire

// ===== rtl/core/clmc_cell.sv =====
// ----------------------------------------------------------------------------
// clmc_cell
// One recency position of the cache: holds an entry, compares it against
// the current item and shifts in its front neighbor's entry on request.
// ----------------------------------------------------------------------------
`default_nettype none

module clmc_cell
  import clmc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  clmc_req_t            req_i,
  input  clmc_cell_ctl_t       ctl_i,
  input  clmc_entry_t          prev_i,
  output clmc_entry_t          ent_o,
  output clmc_cell_flag_t      flag_o
);

  logic [15:0] owner_q, owner_d;
  logic [15:0] index_q;
  logic [15:0] disk_q;
  logic        own_match;

  assign own_match = (owner_q == req_i.file_start);

  // Compare against the item
  always_comb begin
    flag_o.cand = own_match && (index_q <= req_i.req_index);
    flag_o.hit  = own_match && (index_q == req_i.hint_file);
  end

  // Owner: shift in, free on clear, else hold
  always_comb begin
    owner_d = owner_q;
    if (ctl_i.shift) begin
      owner_d = prev_i.owner;
    end else if (ctl_i.clear && own_match) begin
      owner_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
    end else begin
      owner_q <= owner_d;
    end
  end

  // Payload: shift in with the owner
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      index_q <= prev_i.index;
      disk_q  <= prev_i.disk;
    end
  end

  assign ent_o = '{owner: owner_q, index: index_q, disk: disk_q};

endmodule

`default_nettype wire

// ===== rtl/core/clmc_best.sv =====
// ----------------------------------------------------------------------------
// clmc_best
// Tree selection of the candidate entry with the largest index; on equal
// indices the more recent position wins.
// ----------------------------------------------------------------------------
`default_nettype none

module clmc_best
  import clmc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = CacheEntriesDef
) (
  input  wire logic [CACHE_ENTRIES-1:0] cand_i,
  input  clmc_entry_t [CACHE_ENTRIES-1:0] ent_i,
  output logic                          vld_o,
  output logic [15:0]                   index_o,
  output logic [15:0]                   disk_o
);

  localparam int unsigned NumLeaf = 1 << $clog2(CACHE_ENTRIES);

  logic        node_vld [2*NumLeaf];
  logic [15:0] node_idx [2*NumLeaf];
  logic [15:0] node_dsk [2*NumLeaf];

  // Fill leaves, then reduce pairwise toward the root
  always_comb begin
    node_vld[0] = 1'b0;
    node_idx[0] = '0;
    node_dsk[0] = '0;
    for (int j = 0; j < NumLeaf; j++) begin
      if (j < CACHE_ENTRIES) begin
        node_vld[NumLeaf+j] = cand_i[j];
        node_idx[NumLeaf+j] = ent_i[j].index;
        node_dsk[NumLeaf+j] = ent_i[j].disk;
      end else begin
        node_vld[NumLeaf+j] = 1'b0;
        node_idx[NumLeaf+j] = '0;
        node_dsk[NumLeaf+j] = '0;
      end
    end
    for (int i = NumLeaf - 1; i >= 1; i--) begin
      if (node_vld[2*i+1] &&
          (!node_vld[2*i] || (node_idx[2*i+1] > node_idx[2*i]))) begin
        node_vld[i] = 1'b1;
        node_idx[i] = node_idx[2*i+1];
        node_dsk[i] = node_dsk[2*i+1];
      end else begin
        node_vld[i] = node_vld[2*i];
        node_idx[i] = node_idx[2*i];
        node_dsk[i] = node_dsk[2*i];
      end
    end
  end

  assign vld_o   = node_vld[1];
  assign index_o = node_idx[1];
  assign disk_o  = node_dsk[1];

endmodule

`default_nettype wire

// ===== rtl/core/cluster_map_lru_cache_unit.sv =====
// ----------------------------------------------------------------------------
// cluster_map_lru_cache_unit
// Move-to-front cache of file cluster to disk cluster translations.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result appears on
// rsp_o with result_valid_o high for exactly one cycle, once the item held in req_q
// has had its result registered in rsp_q; the receiver cannot stall it, so it must take it then.
// busy is high only while the accepted item is being updated, so a new item can be taken
// in the same cycle its predecessor's result is shown. No new item is taken
// during the update cycle, in which the row of cells compares every entry in
// parallel and then shifts or frees entries.
// Entries are kept in recency order, most recent at cell 0. No clearing pass
// runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cluster_map_lru_cache_unit_assert.svh"

module cluster_map_lru_cache_unit
  import clmc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = CacheEntriesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  clmc_req_t req_i,
  output logic      result_valid_o,
  output clmc_rsp_t rsp_o
);

  clmc_req_t       req_q;
  logic            req_vld_q;
  clmc_rsp_t       rsp_q, rsp_d;
  logic            rsp_vld_q;

  clmc_entry_t     [CACHE_ENTRIES-1:0] ent;
  clmc_entry_t     [CACHE_ENTRIES-1:0] prev;
  clmc_cell_flag_t [CACHE_ENTRIES-1:0] flag;
  clmc_cell_ctl_t  [CACHE_ENTRIES-1:0] ctl;
  logic            [CACHE_ENTRIES-1:0] cand;
  logic            [CACHE_ENTRIES-1:0] hit_first;
  logic            [CACHE_ENTRIES-1:0] shift_mask;

  logic        best_vld;
  logic [15:0] best_idx;
  logic [15:0] best_dsk;
  logic        hit_any;
  logic [15:0] hit_disk;
  logic        add_act;
  logic        do_shift;
  logic        do_clear;
  logic        take_hint;

  // Capture the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  assign busy = req_vld_q;

  // Row of cells; cell 0 takes the entry being stored
  for (genvar p = 0; p < CACHE_ENTRIES; p++) begin : g_cell
    if (p == 0) begin : g_head
      assign prev[p] = '{owner: req_q.file_start, index: req_q.hint_file,
                         disk: req_q.hint_disk};
    end else begin : g_link
      assign prev[p] = ent[p-1];
    end

    assign cand[p] = flag[p].cand;

    clmc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req_q),
      .ctl_i  (ctl[p]),
      .prev_i (prev[p]),
      .ent_o  (ent[p]),
      .flag_o (flag[p])
    );
  end

  clmc_best #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_best (
    .cand_i  (cand),
    .ent_i   (ent),
    .vld_o   (best_vld),
    .index_o (best_idx),
    .disk_o  (best_dsk)
  );

  // Find the most recent hit and mark it and the cells in front of it
  always_comb begin
    logic seen;
    logic tail;
    seen     = 1'b0;
    hit_disk = '0;
    for (int p = 0; p < CACHE_ENTRIES; p++) begin
      hit_first[p] = flag[p].hit && !seen;
      seen         = seen | flag[p].hit;
      if (hit_first[p]) begin
        hit_disk = ent[p].disk;
      end
    end
    hit_any = seen;
    tail    = 1'b0;
    for (int p = CACHE_ENTRIES - 1; p >= 0; p--) begin
      tail          = tail | hit_first[p];
      shift_mask[p] = tail;
    end
  end

  // Decode the item and build the result
  always_comb begin
    rsp_d     = '0;
    do_shift  = 1'b0;
    do_clear  = 1'b0;
    add_act   = 1'b0;
    take_hint = 1'b0;
    unique case (req_q.func)
      FuncLookup: begin
        rsp_d.new_hint_file = req_q.hint_file;
        rsp_d.new_hint_disk = req_q.hint_disk;
        if (req_q.file_start != '0) begin
          take_hint = (req_q.hint_disk != '0) &&
                      (req_q.hint_file <= req_q.req_index);
          rsp_d.found_file = take_hint ? req_q.hint_file : '0;
          rsp_d.found_disk = take_hint ? req_q.hint_disk : req_q.file_start;
          if (best_vld && (best_idx > rsp_d.found_file)) begin
            rsp_d.found_file = best_idx;
            rsp_d.found_disk = best_dsk;
          end
        end
      end
      FuncAdd: begin
        rsp_d.new_hint_file = req_q.hint_file;
        rsp_d.new_hint_disk = req_q.hint_disk;
        add_act = (req_q.req_index != '0) && (req_q.file_start != '0) &&
                  (req_q.hint_file != req_q.req_index);
        if (add_act) begin
          rsp_d.new_hint_file = req_q.req_index;
          rsp_d.new_hint_disk = req_q.req_disk;
          if (req_q.hint_file != '0) begin
            if (hit_any && (hit_disk != req_q.hint_disk)) begin
              rsp_d.corrupt       = 1'b1;
              rsp_d.new_hint_file = '0;
              rsp_d.new_hint_disk = '0;
              do_clear            = 1'b1;
            end else begin
              do_shift = 1'b1;
            end
          end
        end
      end
      FuncInval: begin
        do_clear = 1'b1;
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  // Drive cell controls: a miss shifts the whole row, a hit up to itself
  always_comb begin
    for (int p = 0; p < CACHE_ENTRIES; p++) begin
      ctl[p].shift = req_vld_q && do_shift && (!hit_any || shift_mask[p]);
      ctl[p].clear = req_vld_q && do_clear;
    end
  end

  // Register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = rsp_vld_q;
  assign rsp_o          = rsp_q;

  // Checks
  `CLMC_ASSERT(a_result_follows, busy |=> result_valid_o, "result missing after item")
  `CLMC_ASSERT_NEVER(a_no_overlap, busy && result_valid_o, "busy overlaps result")
  `CLMC_ASSERT(a_corrupt_on_add,
               result_valid_o && rsp_o.corrupt |-> $past(req_q.func) == FuncAdd,
               "corrupt on non-add item")
  `CLMC_ASSERT_NEVER(a_corrupt_hint,
                     result_valid_o && rsp_o.corrupt &&
                     (rsp_o.new_hint_file != '0 || rsp_o.new_hint_disk != '0),
                     "corrupt result keeps a hint")

endmodule

`default_nettype wire
